// ===== rtl/multi_key_click_detector_defines.svh =====
// ----------------------------------------------------------------------------
// multi-key click detector assertion macros
// shared property wrappers for the detector rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_KEY_CLICK_DETECTOR_DEFINES_SVH
`define MULTI_KEY_CLICK_DETECTOR_DEFINES_SVH

// same-cycle implication
`define MKCD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mkcd assertion failed");

// next-cycle implication
`define MKCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mkcd assertion failed");

`endif

// ===== rtl/mkcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mkcd_pkg
// shared types and codes of the multi-key click detector
// ----------------------------------------------------------------------------
package mkcd_pkg;

   localparam int KEY_SLOTS = 8;
   localparam int KEY_W     = 3;
   localparam int TIME_W    = 32;
   localparam int THR_W     = 16;
   localparam int MASK_W    = 8;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int REQ_DAT_W = 40;
   localparam int RSP_DAT_W = 40;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DBL_WIN   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_LOW   = 8'd3;

   typedef enum logic [1:0] {
      ST_IDLE     = 2'd0,
      ST_DEBOUNCE = 2'd1,
      ST_PRESSED  = 2'd2,
      ST_WAIT2    = 2'd3
   } key_fsm_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_RELEASE = 3'd2,
      EV_LONG    = 3'd3,
      EV_SHORT   = 3'd4,
      EV_DOUBLE  = 3'd5
   } event_type;

   // per-key state word held in the state memory
   typedef struct packed {
      key_fsm_type       fsm;
      logic              sampled;
      logic              stable;
      logic [TIME_W-1:0] deb_start;
      logic [TIME_W-1:0] press_start;
      logic [TIME_W-1:0] rel_time;
      logic              long_fired;
      logic [1:0]        clicks;
   } key_state_type;

   typedef struct packed {
      logic [THR_W-1:0] debounce_time;
      logic [THR_W-1:0] long_press_time;
      logic [THR_W-1:0] dbl_window;
   } thresh_type;

   typedef struct packed {
      event_type         code;
      logic [TIME_W-1:0] dur;
   } key_event_type;

endpackage

// ===== rtl/mkcd_update.sv =====
// ----------------------------------------------------------------------------
// mkcd_update
// next-state and event logic of one key's click state machine
// ----------------------------------------------------------------------------
module mkcd_update (
   input  mkcd_pkg::key_state_type cur,
   input  logic                    lvl,
   input  logic [31:0]             now_ms,
   input  mkcd_pkg::thresh_type    thr,
   output mkcd_pkg::key_state_type nxt,
   output mkcd_pkg::key_event_type evt
);
   import mkcd_pkg::*;

   logic [TIME_W-1:0] since_deb;
   logic [TIME_W-1:0] since_press;
   logic [TIME_W-1:0] since_rel;
   logic              deb_done;
   logic              long_due;
   logic              win_over;

   assign since_deb   = now_ms - cur.deb_start;
   assign since_press = now_ms - cur.press_start;
   assign since_rel   = now_ms - cur.rel_time;
   assign deb_done    = since_deb   >= {16'd0, thr.debounce_time};
   assign long_due    = since_press >= {16'd0, thr.long_press_time};
   assign win_over    = since_rel   >  {16'd0, thr.dbl_window};

   always_comb begin
      nxt      = cur;
      evt.code = EV_NONE;
      evt.dur  = '0;
      unique case (cur.fsm)
         ST_IDLE: begin
            if (lvl != cur.stable) begin
               nxt.fsm       = ST_DEBOUNCE;
               nxt.deb_start = now_ms;
               nxt.sampled   = lvl;
            end
            // pending clicks expire silently
            if ((cur.clicks != 2'd0) && win_over) begin
               nxt.clicks = 2'd0;
            end
         end
         ST_DEBOUNCE: begin
            if (lvl != cur.sampled) begin
               nxt.sampled   = lvl;
               nxt.deb_start = now_ms;
            end else if (deb_done) begin
               if (cur.sampled && !cur.stable) begin
                  nxt.fsm         = ST_PRESSED;
                  nxt.press_start = now_ms;
                  nxt.long_fired  = 1'b0;
                  nxt.stable      = 1'b1;
                  evt.code        = EV_PRESS;
               end else if (!cur.sampled && cur.stable) begin
                  nxt.fsm      = ST_WAIT2;
                  nxt.rel_time = now_ms;
                  nxt.stable   = 1'b0;
                  if (cur.clicks != 2'd2) begin
                     nxt.clicks = cur.clicks + 2'd1;
                  end
                  evt.code = EV_RELEASE;
                  evt.dur  = since_press;
               end else begin
                  // settled back on the old level
                  nxt.fsm = ST_IDLE;
               end
            end
         end
         ST_PRESSED: begin
            if (lvl != cur.stable) begin
               nxt.fsm       = ST_DEBOUNCE;
               nxt.deb_start = now_ms;
               nxt.sampled   = lvl;
            end else if (!cur.long_fired && long_due) begin
               nxt.long_fired = 1'b1;
               evt.code       = EV_LONG;
               evt.dur        = since_press;
            end
         end
         ST_WAIT2: begin
            if (lvl && !cur.stable) begin
               nxt.fsm       = ST_DEBOUNCE;
               nxt.deb_start = now_ms;
               nxt.sampled   = lvl;
            end else if (win_over) begin
               if (cur.clicks == 2'd1) begin
                  evt.code = EV_SHORT;
               end else if (cur.clicks >= 2'd2) begin
                  evt.code = EV_DOUBLE;
               end
               nxt.clicks = 2'd0;
               nxt.fsm    = ST_IDLE;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== rtl/multi_key_click_detector.sv =====
// ----------------------------------------------------------------------------
// multi_key_click_detector
// debounce, long press and double click detection for several keys
// ----------------------------------------------------------------------------
// Each req beat is one timestamped raw sample of one key; each one gives
// exactly one rsp beat, in order, carrying the key's event (none, press,
// release, long press, short press or double click), the hold time for
// release and long press, and the debounced key level. Per-key state lives in
// a state memory with a registered read port: a sample is read in the cycle
// it is accepted, updated and written back as its result drops into the
// output register. Back-to-back samples of the same key are served by
// forwarding the word being written, so one sample is accepted every cycle
// unless the event channel stalls. Thresholds and the active-low mask are
// shared by all keys and must only be written while no sample is in flight.
// Samples whose key index is NUM_KEYS or more change nothing and report no
// event with key_down low. The state memory's reset is done by per-entry
// valid bits, so the block is usable right after reset.
// ----------------------------------------------------------------------------
`include "multi_key_click_detector_defines.svh"

module multi_key_click_detector #(
   parameter int NUM_KEYS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // sample channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // key_id[2:0], raw_level[3], now_ms[35:4], zero fill[39:36]
   input  logic [mkcd_pkg::REQ_DAT_W-1:0]   req_tdata,
   // event channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // event_key[2:0], event_code[5:3], hold_duration[37:6], key_down[38],
   // zero fill[39]
   output logic [mkcd_pkg::RSP_DAT_W-1:0]   rsp_tdata,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mkcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mkcd_pkg::CSR_DAT_W-1:0]   csr_data
);
   import mkcd_pkg::*;

   // only the first eight keys can be addressed by the 3-bit key index
   localparam int DEPTH  = (NUM_KEYS < KEY_SLOTS) ? NUM_KEYS : KEY_SLOTS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // shared thresholds
   thresh_type          thr_ff;
   logic [MASK_W-1:0]   act_low_ff;

   // request fields
   logic [KEY_W-1:0]    req_key;
   logic                req_raw;
   logic [TIME_W-1:0]   req_now;
   logic [ADDR_W-1:0]   req_addr;
   logic                req_in_range;
   logic                req_acc;

   // update stage
   logic                s1_vld_ff;
   logic [KEY_W-1:0]    s1_key_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                s1_raw_ff;
   logic [TIME_W-1:0]   s1_now_ff;
   logic                s1_in_range_ff;
   logic                s1_adv;
   logic                s1_wr;

   // state memory, valid bits and forwarding
   key_state_type       mem_ff [DEPTH];
   logic [DEPTH-1:0]    ent_vld_ff;
   key_state_type       rd_q_ff;
   logic                rd_vld_ff;
   logic                fwd_ff;
   key_state_type       fwd_q_ff;
   key_state_type       cur_state;
   key_state_type       nxt_state;
   key_event_type       evt;
   logic                lvl;

   // output register
   logic                rsp_vld_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   event_type           rsp_code_ff;
   logic [TIME_W-1:0]   rsp_dur_ff;
   logic                rsp_down_ff;

   // unpack the sample beat
   assign req_key      = req_tdata[KEY_W-1:0];
   assign req_raw      = req_tdata[KEY_W];
   assign req_now      = req_tdata[KEY_W+TIME_W:KEY_W+1];
   assign req_addr     = req_key[ADDR_W-1:0];
   assign req_in_range = 32'(req_key) < 32'(NUM_KEYS);

   // the update stage drains into the output register when it is free
   assign s1_adv     = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;
   assign s1_wr      = s1_vld_ff && s1_adv && s1_in_range_ff;

   // thresholds are shared; writes take effect at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.debounce_time   <= 16'd20;
         thr_ff.long_press_time <= 16'd1000;
         thr_ff.dbl_window      <= 16'd300;
         act_low_ff             <= 8'hff;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE: thr_ff.debounce_time   <= csr_data;
            CSR_LONG:     thr_ff.long_press_time <= csr_data;
            CSR_DBL_WIN:  thr_ff.dbl_window      <= csr_data;
            CSR_ACT_LOW:  act_low_ff             <= csr_data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // update stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_acc) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   // update stage payload, memory read and forwarding capture
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_key_ff      <= req_key;
         s1_addr_ff     <= req_addr;
         s1_raw_ff      <= req_raw;
         s1_now_ff      <= req_now;
         s1_in_range_ff <= req_in_range;
         rd_q_ff        <= mem_ff[req_addr];
         rd_vld_ff      <= ent_vld_ff[req_addr];
         // the word written this edge is not yet visible at the read port
         fwd_ff         <= s1_wr && (s1_key_ff == req_key);
         fwd_q_ff       <= nxt_state;
      end
   end

   // state memory write port
   always_ff @(posedge clock) begin
      if (s1_wr) begin
         mem_ff[s1_addr_ff] <= nxt_state;
      end
   end

   // entries never written read as the reset state
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
      end else if (s1_wr) begin
         ent_vld_ff[s1_addr_ff] <= 1'b1;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         cur_state = fwd_q_ff;
      end else if (rd_vld_ff) begin
         cur_state = rd_q_ff;
      end else begin
         cur_state = '0;
      end
   end

   // polarity correction
   assign lvl = s1_raw_ff ^ act_low_ff[s1_key_ff];

   mkcd_update u_update (
      .cur    (cur_state),
      .lvl    (lvl),
      .now_ms (s1_now_ff),
      .thr    (thr_ff),
      .nxt    (nxt_state),
      .evt    (evt)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff && s1_adv) begin
         rsp_key_ff <= s1_key_ff;
         if (s1_in_range_ff) begin
            rsp_code_ff <= evt.code;
            rsp_dur_ff  <= evt.dur;
            rsp_down_ff <= nxt_state.stable;
         end else begin
            rsp_code_ff <= EV_NONE;
            rsp_dur_ff  <= '0;
            rsp_down_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_down_ff, rsp_dur_ff, rsp_code_ff, rsp_key_ff};

   // an accepted sample always occupies the update stage next cycle
   `MKCD_ASSERT_NEXT(a_acc_fills_s1, clock, reset, req_acc, s1_vld_ff)
   // a press always leaves the key down
   `MKCD_ASSERT_IMPL(a_press_down, clock, reset,
                     rsp_vld_ff && (rsp_code_ff == EV_PRESS), rsp_down_ff)
   // a release always leaves the key up
   `MKCD_ASSERT_IMPL(a_release_up, clock, reset,
                     rsp_vld_ff && (rsp_code_ff == EV_RELEASE), !rsp_down_ff)
   // only release and long press carry a hold time
   `MKCD_ASSERT_IMPL(a_dur_kind, clock, reset,
                     rsp_vld_ff && (rsp_dur_ff != '0),
                     (rsp_code_ff == EV_RELEASE) || (rsp_code_ff == EV_LONG))

endmodule

// ===== bench/tb_multi_key_click_detector.sv =====
// ----------------------------------------------------------------------------
// tb_multi_key_click_detector
// self-checking bench for the multi-key click detector: a short table of
// hand-worked samples, then randomized press/release scripts over several
// threshold settings, each beat checked against its row or an in-bench tracker
// ----------------------------------------------------------------------------
module tb_multi_key_click_detector;
   timeunit 1ns;
   timeprecision 1ps;

   import mkcd_pkg::*;

   localparam int NUM_KEYS = KEY_SLOTS;
   // an index that maps to no register, the write must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 8'hFC;

   // one event beat as the detector reports it
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      event_type         code;
      logic [TIME_W-1:0] dur;
      logic              down;
   } key_report_type;

   // one row of the directed table; typed rows carry a worked-out event
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic              raw;
      logic [TIME_W-1:0] now;
      logic              typed;
      key_report_type    report;
   } sample_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_DAT_W-1:0] req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DAT_W-1:0] rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   multi_key_click_detector #(.NUM_KEYS(NUM_KEYS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // event tracker: shared thresholds plus a copy of every key's state
   // ------------------------------------------------------------------
   logic [THR_W-1:0]  cfg_debounce;
   logic [THR_W-1:0]  cfg_long;
   logic [THR_W-1:0]  cfg_window;
   logic [MASK_W-1:0] cfg_act_low;

   key_fsm_type       key_fsm     [NUM_KEYS];
   logic              key_sampled [NUM_KEYS];
   logic              key_stable  [NUM_KEYS];
   logic [TIME_W-1:0] key_deb_ms  [NUM_KEYS];
   logic [TIME_W-1:0] key_press_ms[NUM_KEYS];
   logic [TIME_W-1:0] key_rel_ms  [NUM_KEYS];
   logic              key_long_done[NUM_KEYS];
   logic [1:0]        key_clicks  [NUM_KEYS];

   // events still owed by the detector, oldest first
   key_report_type pending_reports[$];

   int unsigned samples_sent = 0;
   int unsigned mismatches = 0;
   int unsigned event_tally[0:7];

   // stimulus knobs, percent of cycles spent idle or stalled
   int unsigned req_idle_pct = 16;
   int unsigned rsp_stall_pct = 66;

   // random script per key: intended pressed level and when it flips next
   logic              gen_pressed[NUM_KEYS];
   logic [TIME_W-1:0] gen_flip_ms[NUM_KEYS];
   logic [TIME_W-1:0] wall_ms;

   function automatic void clear_tracker();
      cfg_debounce = 16'd20;
      cfg_long     = 16'd1000;
      cfg_window   = 16'd300;
      cfg_act_low  = 8'hFF;
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_fsm[k]       = ST_IDLE;
         key_sampled[k]   = 1'b0;
         key_stable[k]    = 1'b0;
         key_deb_ms[k]    = '0;
         key_press_ms[k]  = '0;
         key_rel_ms[k]    = '0;
         key_long_done[k] = 1'b0;
         key_clicks[k]    = '0;
         gen_pressed[k]   = 1'b0;
         gen_flip_ms[k]   = '0;
      end
      for (int c = 0; c < 8; c++)
         event_tally[c] = 0;
   endfunction

   function automatic void start_debounce(input int unsigned k, input logic lvl,
                                          input logic [TIME_W-1:0] now);
      key_fsm[k]     = ST_DEBOUNCE;
      key_deb_ms[k]  = now;
      key_sampled[k] = lvl;
   endfunction

   // steps one key's machine and returns the event it reports
   function automatic key_report_type advance_key_fsm(input logic [KEY_W-1:0] key,
                                                      input logic raw,
                                                      input logic [TIME_W-1:0] now);
      key_report_type rep;
      logic           lvl;
      int unsigned    k;
      k        = key;
      rep.key  = key;
      rep.code = EV_NONE;
      rep.dur  = '0;
      rep.down = 1'b0;
      // keys beyond the instance change nothing and report released
      if (k >= NUM_KEYS)
         return rep;
      // polarity correction: active-low keys read pressed on a low pin
      lvl = cfg_act_low[k] ? ~raw : raw;
      case (key_fsm[k])
         ST_IDLE: begin
            if (lvl != key_stable[k])
               start_debounce(k, lvl, now);
            // stale clicks from an expired window vanish without an event
            if (key_clicks[k] != 0 && now - key_rel_ms[k] > cfg_window)
               key_clicks[k] = '0;
         end
         ST_DEBOUNCE: begin
            if (lvl != key_sampled[k]) begin
               key_sampled[k] = lvl;
               key_deb_ms[k]  = now;
            end else if (now - key_deb_ms[k] >= cfg_debounce) begin
               if (key_sampled[k] && !key_stable[k]) begin
                  key_fsm[k]       = ST_PRESSED;
                  key_press_ms[k]  = now;
                  key_long_done[k] = 1'b0;
                  key_stable[k]    = 1'b1;
                  rep.code         = EV_PRESS;
               end else if (!key_sampled[k] && key_stable[k]) begin
                  // release reports the full hold time
                  rep.dur       = now - key_press_ms[k];
                  key_fsm[k]    = ST_WAIT2;
                  key_rel_ms[k] = now;
                  key_stable[k] = 1'b0;
                  if (key_clicks[k] < 2)
                     key_clicks[k] = key_clicks[k] + 2'd1;
                  rep.code = EV_RELEASE;
               end else begin
                  // bounce settled back on the old level, quietly
                  key_fsm[k] = ST_IDLE;
               end
            end
         end
         ST_PRESSED: begin
            if (lvl != key_stable[k]) begin
               start_debounce(k, lvl, now);
            end else if (!key_long_done[k] && now - key_press_ms[k] >= cfg_long) begin
               key_long_done[k] = 1'b1;
               rep.code         = EV_LONG;
               rep.dur          = now - key_press_ms[k];
            end
         end
         default: begin
            if (lvl && !key_stable[k]) begin
               start_debounce(k, lvl, now);
            end else if (now - key_rel_ms[k] > cfg_window) begin
               if (key_clicks[k] == 2'd1)
                  rep.code = EV_SHORT;
               else if (key_clicks[k] >= 2'd2)
                  rep.code = EV_DOUBLE;
               key_clicks[k] = '0;
               key_fsm[k]    = ST_IDLE;
            end
         end
      endcase
      rep.down = key_stable[k];
      return rep;
   endfunction

   // ------------------------------------------------------------------
   // sample channel driver
   // ------------------------------------------------------------------
   task automatic send_sample(input logic [KEY_W-1:0] key, input logic raw,
                              input logic [TIME_W-1:0] now, input logic typed,
                              input key_report_type typed_report);
      key_report_type predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, now, raw, key};
      do @(posedge clock); while (!req_tready);
      // beat taken at this edge, bring the tracker along
      predicted = advance_key_fsm(key, raw, now);
      pending_reports.push_back(typed ? typed_report : predicted);
      samples_sent++;
   endtask

   // hold the sample channel until every owed event has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   // keeps csr_valid high; the caller drops it after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_DEBOUNCE: cfg_debounce = data;
         CSR_LONG:     cfg_long     = data;
         CSR_DBL_WIN:  cfg_window   = data;
         CSR_ACT_LOW:  cfg_act_low  = data[MASK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [THR_W-1:0] debounce,
                                 input logic [THR_W-1:0] long_hold,
                                 input logic [THR_W-1:0] window,
                                 input logic [CSR_DAT_W-1:0] mask_word);
      wait_drained();
      write_csr(CSR_DEBOUNCE, debounce);
      write_csr(CSR_LONG, long_hold);
      write_csr(CSR_DBL_WIN, window);
      // upper byte of the mask word is junk that must be dropped
      write_csr(CSR_ACT_LOW, mask_word);
      write_csr(CSR_UNUSED, CSR_DAT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // random hold or gap length, scaled to the current thresholds
   function automatic int unsigned hold_span(input logic pressed, input int unsigned tick);
      int unsigned deb;
      int unsigned lng;
      int unsigned win;
      deb = cfg_debounce;
      lng = cfg_long;
      win = cfg_window;
      case ($urandom_range(0, 3))
         // bounce, no longer than the filter
         0: return $urandom_range(0, deb);
         // long hold, or a gap that lets the click window expire
         3: return pressed ? $urandom_range(deb + lng, deb + 2 * lng + tick)
                           : $urandom_range(deb + win, 2 * (deb + win) + 16 * tick);
         // ordinary click, or a gap short enough for a second click
         default: return pressed ? $urandom_range(deb, deb + lng)
                                 : $urandom_range(deb, deb + win);
      endcase
   endfunction

   // mostly well-formed press scripts on a focus pair of keys, with glitches
   // and the occasional sample at a random time stamp mixed in
   task automatic run_phase(input int unsigned count, input logic [TIME_W-1:0] start_ms);
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] focus;
      logic             raw;
      int unsigned      tick;
      focus   = KEY_W'($urandom_range(0, NUM_KEYS - 1));
      wall_ms = start_ms;
      tick    = (int'(cfg_debounce) + int'(cfg_window)) / 8 + 1;
      for (int k = 0; k < NUM_KEYS; k++)
         gen_flip_ms[k] = start_ms;
      repeat (count) begin
         key = ($urandom_range(0, 3) != 0) ? KEY_W'(focus + $urandom_range(0, 1))
                                           : KEY_W'($urandom_range(0, NUM_KEYS - 1));
         wall_ms = wall_ms + $urandom_range(0, tick);
         if ($urandom_range(0, 14) == 0) begin
            send_sample(KEY_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                        $urandom, 1'b0, '0);
         end else begin
            if ($signed(wall_ms - gen_flip_ms[key]) >= 0) begin
               gen_pressed[key] = !gen_pressed[key];
               gen_flip_ms[key] = wall_ms + hold_span(gen_pressed[key], tick);
            end
            raw = gen_pressed[key] ^ cfg_act_low[key];
            if ($urandom_range(0, 11) == 0)
               raw = !raw;
            send_sample(key, raw, wall_ms, 1'b0, '0);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // directed table, worked out at reset thresholds (20 / 1000 / 300, all
   // keys active low so a 0 on the pin means pressed)
   // ------------------------------------------------------------------
   sample_row_type directed_rows[0:23] = '{
      // key 0: released pin, then a clean press at the exact debounce edge
      '{3'd0, 1'b1, 32'd0,    1'b1, '{3'd0, EV_NONE,    32'd0,    1'b0}},
      '{3'd0, 1'b0, 32'd100,  1'b1, '{3'd0, EV_NONE,    32'd0,    1'b0}},
      '{3'd0, 1'b0, 32'd119,  1'b1, '{3'd0, EV_NONE,    32'd0,    1'b0}},
      '{3'd0, 1'b0, 32'd120,  1'b1, '{3'd0, EV_PRESS,   32'd0,    1'b1}},
      // long press one ms short, then right on the threshold, then once only
      '{3'd0, 1'b0, 32'd1119, 1'b1, '{3'd0, EV_NONE,    32'd0,    1'b1}},
      '{3'd0, 1'b0, 32'd1120, 1'b1, '{3'd0, EV_LONG,    32'd1000, 1'b1}},
      '{3'd0, 1'b0, 32'd5000, 1'b0, '0},
      // release bounces back and settles on the held level
      '{3'd0, 1'b1, 32'd5010, 1'b0, '0},
      '{3'd0, 1'b0, 32'd5015, 1'b0, '0},
      '{3'd0, 1'b0, 32'd5040, 1'b0, '0},
      // real release carries the hold time, window runs out to a short press
      '{3'd0, 1'b1, 32'd5100, 1'b0, '0},
      '{3'd0, 1'b1, 32'd5120, 1'b1, '{3'd0, EV_RELEASE, 32'd5000, 1'b0}},
      '{3'd0, 1'b1, 32'd5420, 1'b0, '0},
      '{3'd0, 1'b1, 32'd5421, 1'b1, '{3'd0, EV_SHORT,   32'd0,    1'b0}},
      // key 7: debounce across the time stamp wrap, then a double click
      '{3'd7, 1'b0, 32'hFFFF_FFF0, 1'b0, '0},
      '{3'd7, 1'b0, 32'd4,    1'b1, '{3'd7, EV_PRESS,   32'd0,    1'b1}},
      '{3'd7, 1'b1, 32'd16,   1'b0, '0},
      '{3'd7, 1'b1, 32'd36,   1'b1, '{3'd7, EV_RELEASE, 32'd32,   1'b0}},
      '{3'd7, 1'b0, 32'd100,  1'b0, '0},
      '{3'd7, 1'b0, 32'd120,  1'b0, '0},
      '{3'd7, 1'b1, 32'd130,  1'b0, '0},
      '{3'd7, 1'b1, 32'd150,  1'b0, '0},
      '{3'd7, 1'b1, 32'd451,  1'b1, '{3'd7, EV_DOUBLE,  32'd0,    1'b0}},
      // largest time stamp on an untouched key
      '{3'd3, 1'b1, 32'hFFFF_FFFF, 1'b1, '{3'd3, EV_NONE, 32'd0,  1'b0}}
   };

   // ------------------------------------------------------------------
   // event channel: random back-pressure and the checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : event_check
      key_report_type want;
      key_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.key  = rsp_tdata[2:0];
         got.code = event_type'(rsp_tdata[5:3]);
         got.dur  = rsp_tdata[37:6];
         got.down = rsp_tdata[38];
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: event beat with nothing owed: key %0d code %0d dur %0d down %0b",
                        $realtime, got.key, got.code, got.dur, got.down);
         end else begin
            want = pending_reports.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: event mismatch: got key %0d code %0d dur %0d down %0b,",
                            " expected key %0d code %0d dur %0d down %0b"},
                           $realtime, got.key, got.code, got.dur, got.down,
                           want.key, want.code, want.dur, want.down);
            end
            event_tally[rsp_tdata[5:3]]++;
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      clear_tracker();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows at reset thresholds
      foreach (directed_rows[i])
         send_sample(directed_rows[i].key, directed_rows[i].raw, directed_rows[i].now,
                     directed_rows[i].typed, directed_rows[i].report);

      // sender light, receiver stalling hard
      req_idle_pct  = 16;
      rsp_stall_pct = 66;
      apply_settings(16'd3, 16'd60, 16'd25, 16'h5AA5);
      run_phase(400, 32'h0000_1000);

      // the other way round; zero thresholds and active-high keys, with the
      // script starting just below the time stamp wrap
      req_idle_pct  = 66;
      rsp_stall_pct = 16;
      apply_settings(16'd0, 16'd0, 16'd0, 16'hFF00);
      run_phase(350, 32'hFFFF_FF80);

      // no idling from here on; largest thresholds first
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
      run_phase(200, 32'h7FFF_0000);

      apply_settings(16'd5, 16'd150, 16'd40, 16'hC33C);
      run_phase(450, $urandom);

      // let the tail drain and give the pipe time to show stray beats
      wait_drained();
      repeat (8) @(posedge clock);

      $display("covered %0d key samples over five threshold settings, zero and full scale,",
               samples_sent);
      $display("  events: press %0d release %0d long %0d short %0d double %0d",
               event_tally[EV_PRESS], event_tally[EV_RELEASE], event_tally[EV_LONG],
               event_tally[EV_SHORT], event_tally[EV_DOUBLE]);
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mkcd_pkg.sv
rtl/mkcd_update.sv
rtl/multi_key_click_detector.sv
bench/tb_multi_key_click_detector.sv
